/* hdl/rc5_pkg.sv */
// Package for the RC5 infrared frame encoder: beat types, constants and sequencer states.
`default_nettype none
package rc5_pkg;

	// Default for the payload bit limit.
	localparam int MAX_FRAME_BITS_DEF = 11;
	// Half-bit time after reset, in microseconds.
	localparam logic [15:0] HALF_BIT_RST = 16'd889;

	localparam int DATA_W  = 11;
	localparam int COUNT_W = 4;
	localparam int DUR_W   = 16;
	localparam int ALIGN_W = 22;
	// Left-aligned payload window: it holds any count a 4-bit field can carry.
	localparam int WIN_W   = 16;
	// Two start bits and the toggle bit ahead of the payload.
	localparam int HEAD_W  = 3;
	localparam int SR_W    = HEAD_W + WIN_W;
	localparam int BITS_W  = 5;

	typedef struct packed {
		logic [DATA_W-1:0]  data;
		logic [COUNT_W-1:0] bit_count;
	} req_t;

	typedef struct packed {
		logic             carrier_on;
		logic [DUR_W-1:0] duration_us;
		logic             last;
	} res_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} seq_state_t;

endpackage
`default_nettype wire

/* hdl/rc5_ir_frame_encoder.sv */
// RC5-style Manchester frame encoder: emits one half-bit interval beat per cycle while the
// receiver does not stall. The first beat is registered once the sequencer is running.
// Each frame gives 6 + 2*bit_count result beats (bit_count clamped to MAX_FRAME_BITS),
// shifted out of a bit shift register; a new request is taken once the last beat is in the
// output register.
// Reset (arst_n, asynchronous): half-bit time 889, toggle clear, no previous frame stored.
`default_nettype none
module rc5_ir_frame_encoder import rc5_pkg::*; #(
	parameter int MAX_FRAME_BITS = MAX_FRAME_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	// frame requests
	input  wire logic             req_valid,
	output      logic             req_stall,
	input  wire req_t             req,
	// half-bit beats
	output      logic             res_valid,
	input  wire logic             res_stall,
	output      res_t             res,
	// half-bit time register
	input  wire logic             cfg_valid,
	output      logic             cfg_ready,
	input  wire logic [DUR_W-1:0] cfg_data
);

	localparam logic [BITS_W-1:0] MAX_CNT = BITS_W'(MAX_FRAME_BITS);

	seq_state_t          state_q, state_nxt;
	logic [DUR_W-1:0]    half_bit_q;
	logic                toggle_q;
	logic                prev_valid_q;
	logic [ALIGN_W-1:0]  prev_q;
	logic [SR_W-1:0]     sr_q;
	logic [BITS_W-1:0]   bits_q;
	logic                phase_q;
	logic                res_valid_q;
	res_t                res_q;

	logic                accept;
	logic                adv;
	logic                done;
	logic [BITS_W-1:0]   cnt_c;
	logic [BITS_W-1:0]   shamt;
	logic [ALIGN_W-1:0]  aligned;
	logic                toggle_nxt;
	logic [WIN_W-1:0]    win;
	logic                cur_bit;

	// config register, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_bit_q <= HALF_BIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			half_bit_q <= cfg_data;
		end
	end

	// request decode: clamp count, align data, work out the toggle
	always_comb begin
		if ({1'b0, req.bit_count} > MAX_CNT) begin
			cnt_c = MAX_CNT;
		end else begin
			cnt_c = {1'b0, req.bit_count};
		end
		shamt      = MAX_CNT - cnt_c;
		aligned    = ALIGN_W'({{(WIN_W + 1){1'b0}}, req.data} << shamt);
		toggle_nxt = toggle_q ^ (!prev_valid_q || (prev_q != aligned));
		win        = WIN_W'({{(WIN_W - DATA_W){1'b0}}, req.data} << (BITS_W'(WIN_W) - cnt_c));
	end

	assign accept  = req_valid && !req_stall;
	assign adv     = (state_q == ST_RUN) && (!res_valid_q || !res_stall);
	assign done    = adv && phase_q && (bits_q == BITS_W'(1));
	assign cur_bit = sr_q[SR_W-1];

	// sequencer next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_nxt = ST_RUN;
				end
			end
			ST_RUN: begin
				if (done) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		case (state_q)
			ST_IDLE: req_stall = 1'b0;
			ST_RUN:  req_stall = 1'b1;
			default: req_stall = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// toggle and previous-frame memory, updated as a request is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			toggle_q     <= 1'b0;
			prev_valid_q <= 1'b0;
			prev_q       <= '0;
		end else if (accept) begin
			toggle_q     <= toggle_nxt;
			prev_valid_q <= 1'b1;
			prev_q       <= aligned;
		end
	end

	// frame bit shift register: start, start, toggle, payload MSB first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q  <= '0;
			phase_q <= 1'b0;
		end else if (accept) begin
			bits_q  <= BITS_W'(HEAD_W) + cnt_c;
			phase_q <= 1'b0;
		end else if (adv) begin
			phase_q <= !phase_q;
			if (phase_q) begin
				bits_q <= bits_q - BITS_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sr_q <= {1'b1, 1'b1, !toggle_nxt, win};
		end else if (adv && phase_q) begin
			sr_q <= {sr_q[SR_W-2:0], 1'b0};
		end
	end

	// output register: a one is space then pulse, a zero pulse then space
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q.carrier_on  <= phase_q ? cur_bit : !cur_bit;
			res_q.duration_us <= half_bit_q;
			res_q.last        <= phase_q && (bits_q == BITS_W'(1));
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// a taken request starts a frame at its first half with the header still to go
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_RUN) && !phase_q && (bits_q >= BITS_W'(HEAD_W)))
		else $error("frame did not start cleanly");

	// no bits left over once the sequencer is idle
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (bits_q == '0))
		else $error("sequencer idle with bits pending");

	// once a frame has been taken the previous value stays valid
	a_prev_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		$past(prev_valid_q) |-> prev_valid_q)
		else $error("previous-frame flag dropped");

endmodule
`default_nettype wire

/* bench/tb.sv */
// Self-checking RC5 encoder bench: directed and random frames, half-bit extremes, back-pressure.
`timescale 1ns / 100ps
module tb import rc5_pkg::*; ();

	localparam int RESET_CYCLES  = 5;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 300;
	localparam int LIMIT_CYCLES  = 400000;
	localparam int IDLE_PCT      = 25;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             req_valid = 1'b0;
	logic             req_stall;
	req_t             req = '0;
	logic             res_valid;
	logic             res_stall = 1'b0;
	res_t             res;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [DUR_W-1:0] cfg_data = '0;

	// no idling on either side while set
	logic calm = 1'b0;
	// one-beat request for a long receiver hold-off
	logic hold_go = 1'b0;
	int   hold_left = 0;

	int cycle_count = 0;
	int fail_count = 0;

	// encoder state as seen by the bench
	logic [DUR_W-1:0]   half_bit_set = HALF_BIT_RST;
	logic               toggle_bit = 1'b0;
	logic [ALIGN_W-1:0] last_aligned = '0;
	logic               seen_frame = 1'b0;
	res_t               beats_due[$];

	// last request offered, for repeats
	req_t prev_frame = '0;

	rc5_ir_frame_encoder DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Work out the half-bit beats of one frame and queue them
	function automatic void encode_frame(req_t item);
		int unsigned        n;
		int unsigned        nbits;
		logic [ALIGN_W-1:0] aligned;
		logic [13:0]        bits;
		res_t               beat;
		n = (item.bit_count > MAX_FRAME_BITS_DEF) ? MAX_FRAME_BITS_DEF : item.bit_count;
		aligned = ALIGN_W'(item.data) << (MAX_FRAME_BITS_DEF - n);
		if (!seen_frame || last_aligned != aligned)
			toggle_bit = ~toggle_bit;
		bits = '0;
		bits[0] = 1'b1;
		bits[1] = 1'b1;
		bits[2] = ~toggle_bit;
		for (int unsigned i = 0; i < n; i++)
			bits[3 + i] = item.data[n - 1 - i];
		nbits = 3 + n;
		beat.duration_us = half_bit_set;
		// a one is space then pulse, a zero pulse then space
		for (int unsigned i = 0; i < nbits; i++) begin
			beat.carrier_on = ~bits[i];
			beat.last = 1'b0;
			beats_due.push_back(beat);
			beat.carrier_on = bits[i];
			beat.last = (i == nbits - 1);
			beats_due.push_back(beat);
		end
		last_aligned = aligned;
		seen_frame = 1'b1;
	endfunction

	// Random request, often a repeat or the same aligned payload one bit longer
	function automatic req_t pick_frame();
		req_t        item;
		int unsigned r;
		int unsigned n;
		r = $urandom_range(0, 99);
		n = (prev_frame.bit_count > MAX_FRAME_BITS_DEF) ? MAX_FRAME_BITS_DEF
			: prev_frame.bit_count;
		if (r < 20) begin
			item = prev_frame;
		end else if (r < 32 && n < MAX_FRAME_BITS_DEF && !prev_frame.data[DATA_W-1]) begin
			item.data = prev_frame.data << 1;
			item.bit_count = COUNT_W'(n + 1);
		end else begin
			item.data = DATA_W'($urandom());
			if ($urandom_range(0, 99) < 85)
				item.bit_count = COUNT_W'($urandom_range(0, MAX_FRAME_BITS_DEF));
			else
				item.bit_count = COUNT_W'($urandom_range(MAX_FRAME_BITS_DEF + 1, 15));
		end
		return item;
	endfunction

	// Offer one request and wait until it is taken; valid stays high afterwards
	task automatic send_frame(req_t item);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		prev_frame = item;
		do @(posedge clk); while (req_stall);
	endtask

	// Stop offering and wait until every beat has come out
	task automatic drain_frames();
		req_valid <= 1'b0;
		@(posedge clk);
		while (beats_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write the half-bit time while the encoder is idle
	task automatic set_half_bit(logic [DUR_W-1:0] value);
		drain_frames();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		half_bit_set = value;
		cfg_valid <= 1'b0;
	endtask

	task automatic test_directed_frames();
		req_t list[$];
		list = '{
			'{11'h000, 4'd0}, '{11'h000, 4'd0}, '{11'h7FF, 4'd11}, '{11'h7FF, 4'd11},
			'{11'h7FF, 4'd15}, '{11'h7FF, 4'd12}, '{11'h001, 4'd1}, '{11'h002, 4'd2},
			'{11'h004, 4'd3}, '{11'h003, 4'd1}, '{11'h555, 4'd11}, '{11'h2AA, 4'd11},
			'{11'h7FF, 4'd0}, '{11'h400, 4'd11}, '{11'h001, 4'd11}, '{11'h005, 4'd4},
			'{11'h005, 4'd4}, '{11'h000, 4'd15}, '{11'h7FF, 4'd14}, '{11'h123, 4'd13}
		};
		foreach (list[i])
			send_frame(list[i]);
		drain_frames();
	endtask

	task automatic test_half_bit_extremes();
		logic [DUR_W-1:0] values[3];
		values = '{16'd1, 16'hFFFF, 16'd0};
		foreach (values[i]) begin
			set_half_bit(values[i]);
			repeat (6) send_frame(pick_frame());
		end
	endtask

	task automatic test_random_frames();
		for (int phase = 0; phase < 4; phase++) begin
			set_half_bit(DUR_W'($urandom_range(1, 65535)));
			// one phase runs without idling on either side
			calm <= (phase == 2);
			repeat (32) send_frame(pick_frame());
		end
		calm <= 1'b0;
	endtask

	task automatic test_backpressure();
		set_half_bit(HALF_BIT_RST);
		calm <= 1'b1;
		hold_go <= 1'b1;
		@(posedge clk);
		hold_go <= 1'b0;
		repeat (14) send_frame(pick_frame());
		calm <= 1'b0;
		drain_frames();
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_frames();
		test_half_bit_extremes();
		test_random_frames();
		test_backpressure();
		drain_frames();
		repeat (30) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// Predict on each accepted request beat
	always @(posedge clk) begin
		if (arst_n && req_valid && !req_stall)
			encode_frame(req);
	end

	// Receiver stall: random, or held for a long stretch on request
	always @(posedge clk) begin
		if (hold_left > 0) begin
			res_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_go) begin
			res_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
		end else begin
			res_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
		end
	end

	// Compare each accepted result beat with the oldest expected one
	always @(posedge clk) begin : check_beat
		res_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (beats_due.size() == 0) begin
				$display("%0t: unexpected beat, expected none, actual carrier %0b dur %0d last %0b",
					$time, res.carrier_on, res.duration_us, res.last);
				fail_count++;
			end else begin
				want = beats_due.pop_front();
				if (res.carrier_on !== want.carrier_on) begin
					$display("%0t: carrier_on expected %0b actual %0b",
						$time, want.carrier_on, res.carrier_on);
					fail_count++;
				end
				if (res.duration_us !== want.duration_us) begin
					$display("%0t: duration_us expected %0d actual %0d",
						$time, want.duration_us, res.duration_us);
					fail_count++;
				end
				if (res.last !== want.last) begin
					$display("%0t: last expected %0b actual %0b", $time, want.last, res.last);
					fail_count++;
				end
			end
		end
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("%0t: run limit reached with %0d beats outstanding", $time,
				beats_due.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

endmodule

/* files.f */
hdl/rc5_pkg.sv
hdl/rc5_ir_frame_encoder.sv
bench/tb.sv
